### sv/tmav_pkg.sv
// Shared constants and types for the three-axis moving-average filter.
package tmav_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AXES        = 3;
    // The ring index wraps by dropping carry bits, so the depth is a power of two.
    localparam int MAX_WINDOW  = 64;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int ITER_BITS   = $clog2(SUM_BITS);
    localparam int ROW_BITS    = AXES * SAMPLE_BITS;
    localparam int HELD_BITS   = 6;

    localparam logic [HELD_BITS-1:0] HELD_RESET = HELD_BITS'(7);

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        logic [ROW_BITS-1:0]  wr_data;
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
    } ring_req_t;

endpackage

### sv/three_axis_moving_average.sv
// Top level of the three-axis moving-average filter.
//
// Each input beat on s_axis carries one x, y and z acceleration sample. The
// block adds it to a window of the last held_samples + 1 samples (fewer until
// the window has filled) and returns one beat on m_axis with the mean of each
// axis, truncated toward zero. The window length is written on the cfg
// channel; a write also empties the window so averaging starts over.
// The cfg channel is taken only while the block is idle.
//
// A result is formed in steps after its input beat is accepted. The accepting
// edge stores the sample and updates the running sums. In the start state that
// follows, the oldest sample leaves the sums and the dividers start. The three
// bit-serial dividers then run side by side and retire one quotient bit per
// cycle over the 22-bit sums. Once they finish and the output register is free,
// the quotients move into the output register. The next input beat is taken in
// the cycle after the result is loaded, so a new beat is only taken once the
// last one is through.
//
// After reset the window is empty and held_samples is 7. If the receiver
// stalls, the result waits in the output register; the next input beat is
// still accepted and computed, and its result is held back until the output
// register is taken. No further input beat is taken meanwhile.
module three_axis_moving_average
    import tmav_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input samples.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ROW_BITS-1:0]  s_axis_tdata,   // accel_x, accel_y, accel_z from bit 0 up
    // Averages.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ROW_BITS-1:0]  m_axis_tdata,   // avg_x, avg_y, avg_z from bit 0 up
    // held_samples register write.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [HELD_BITS-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_RUN
    } state_t;

    state_t                     state_reg, state_next;
    logic [HELD_BITS-1:0]       held_reg, held_next;
    logic [SLOT_BITS-1:0]       slot_reg, slot_next;
    logic [SLOT_BITS-1:0]       fill_reg, fill_next;
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic signed [SUM_BITS-1:0] sum_reg [AXES];
    logic signed [SUM_BITS-1:0] sum_next [AXES];
    logic [ROW_BITS-1:0]        sample_reg, sample_next;
    logic                       sub_reg, sub_next;
    logic                       self_reg, self_next;
    logic                       m_valid_reg, m_valid_next;
    logic [ROW_BITS-1:0]        m_data_reg, m_data_next;

    logic                       in_accept;
    logic                       cfg_accept;
    logic                       out_free;
    logic                       div_start;
    logic [AXES-1:0]            div_busy;
    logic [SAMPLE_BITS-1:0]     quotient [AXES];
    logic [ROW_BITS-1:0]        ring_rd_data;
    logic [ROW_BITS-1:0]        oldest;
    ring_req_t                  ring_req;

    // Configuration wins over a sample offered in the same idle cycle.
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign div_start     = (state_reg == ST_START);

    // With a single kept sample the oldest entry is the one just written,
    // which is still in the sample register and not yet readable from the ring.
    assign oldest = self_reg ? sample_reg : ring_rd_data;

    always_comb begin
        ring_req.wr_en   = in_accept;
        ring_req.wr_addr = slot_reg;
        ring_req.wr_data = s_axis_tdata;
        ring_req.rd_en   = in_accept;
        ring_req.rd_addr = slot_reg - fill_reg;
    end

    always_comb begin
        state_next   = state_reg;
        held_next    = held_reg;
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        sample_next  = sample_reg;
        sub_next     = sub_reg;
        self_next    = self_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        for (int a = 0; a < AXES; a++) begin
            sum_next[a] = sum_reg[a];
        end

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_accept) begin
                    held_next = cfg_data;
                    slot_next = '0;
                    fill_next = '0;
                    for (int a = 0; a < AXES; a++) begin
                        sum_next[a] = '0;
                    end
                end else if (in_accept) begin
                    for (int a = 0; a < AXES; a++) begin
                        sum_next[a] = sum_reg[a] + SUM_BITS'(signed'(
                            s_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]));
                    end
                    sample_next = s_axis_tdata;
                    count_next  = {1'b0, fill_reg} + 1'b1;
                    // A full window drops its oldest sample once the mean is formed.
                    sub_next    = (fill_reg >= held_reg);
                    self_next   = (fill_reg == '0);
                    slot_next   = slot_reg + 1'b1;
                    fill_next   = (fill_reg >= held_reg) ? fill_reg : fill_reg + 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                // The dividers latch the sums in this cycle, so the oldest
                // sample can leave the running sums at the same edge.
                if (sub_reg) begin
                    for (int a = 0; a < AXES; a++) begin
                        sum_next[a] = sum_reg[a] - SUM_BITS'(signed'(
                            oldest[a*SAMPLE_BITS +: SAMPLE_BITS]));
                    end
                end
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (!div_busy[0] && out_free) begin
                    m_valid_next = 1'b1;
                    for (int a = 0; a < AXES; a++) begin
                        m_data_next[a*SAMPLE_BITS +: SAMPLE_BITS] = quotient[a];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= HELD_RESET;
            slot_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= sum_next[a];
            end
        end
        count_reg  <= count_next;
        sample_reg <= sample_next;
        sub_reg    <= sub_next;
        self_reg   <= self_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    tmav_ring u_ring (
        .aclk      (aclk),
        .req_i     (ring_req),
        .rd_data_o (ring_rd_data)
    );

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        tmav_divider u_div (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .start_i    (div_start),
            .dividend_i (sum_reg[g]),
            .divisor_i  (count_reg),
            .busy_o     (div_busy[g]),
            .quotient_o (quotient[g])
        );
    end

`ifndef SYNTHESIS
    // The number of kept samples never exceeds the configured count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= held_reg)
        else $error("kept sample count exceeds held_samples");

    // The three divider lanes run in lock step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy[0] == div_busy[1] && div_busy[1] == div_busy[2])
        else $error("divider lanes out of step");

    // A register write empties the window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_accept |=> fill_reg == '0 && slot_reg == '0)
        else $error("configuration write did not clear the window");

    // The dividers are busy as the run state begins after their start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_busy[0] && state_reg == ST_RUN)
        else $error("dividers not running after start");
`endif

endmodule

### sv/tmav_ring.sv
// Sample ring: one write port and one registered read port.
module tmav_ring
    import tmav_pkg::*;
(
    input  logic                aclk,
    input  ring_req_t           req_i,
    output logic [ROW_BITS-1:0] rd_data_o
);

    logic [ROW_BITS-1:0] mem [MAX_WINDOW];
    logic [ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req_i.wr_en) begin
            mem[req_i.wr_addr] <= req_i.wr_data;
        end
        if (req_i.rd_en) begin
            rd_data_reg <= mem[req_i.rd_addr];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

### sv/tmav_divider.sv
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
module tmav_divider
    import tmav_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_i,
    input  logic signed [SUM_BITS-1:0]    dividend_i,
    input  logic        [COUNT_BITS-1:0]  divisor_i,
    output logic                          busy_o,
    output logic        [SAMPLE_BITS-1:0] quotient_o
);

    logic                  busy_reg, busy_next;
    logic [ITER_BITS-1:0]  iter_reg, iter_next;
    logic                  neg_reg, neg_next;
    logic [COUNT_BITS-1:0] div_reg, div_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [SUM_BITS-1:0]   shift_reg, shift_next;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  qbit;
    logic [SUM_BITS-1:0]   mag;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
        mag        = dividend_i[SUM_BITS-1] ? SUM_BITS'(-dividend_i) : dividend_i;
        trial      = {rem_reg, shift_reg[SUM_BITS-1]};
        diff       = trial - {1'b0, div_reg};
        qbit       = (trial >= {1'b0, div_reg});
        busy_next  = busy_reg;
        iter_next  = iter_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        if (start_i) begin
            busy_next  = 1'b1;
            iter_next  = ITER_BITS'(SUM_BITS - 1);
            neg_next   = dividend_i[SUM_BITS-1];
            div_next   = divisor_i;
            rem_next   = '0;
            shift_next = mag;
        end else if (busy_reg) begin
            rem_next   = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            shift_next = {shift_reg[SUM_BITS-2:0], qbit};
            iter_next  = iter_reg - 1'b1;
            if (iter_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
        neg_reg   <= neg_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign busy_o     = busy_reg;
    assign quotient_o = neg_reg ? SAMPLE_BITS'(-shift_reg[SAMPLE_BITS-1:0])
                                : shift_reg[SAMPLE_BITS-1:0];

endmodule
